// File: sv/buddy_allocator_with_cpu_caches_unit_assert.svh
// Assertion macros shared by the buddy allocator RTL.
`ifndef BUDDY_ALLOCATOR_WITH_CPU_CACHES_UNIT_ASSERT_SVH
`define BUDDY_ALLOCATOR_WITH_CPU_CACHES_UNIT_ASSERT_SVH

// Checked only outside reset.
`define BAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define BAC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/bac_pkg.sv
// Types, codes and defaults for the buddy allocator with per-CPU page caches.
package bac_pkg;

  localparam int NUM_PAGES_DEF  = 4096;
  localparam int NUM_ORDERS_DEF = 11;
  localparam int NUM_CPUS_DEF   = 4;

  localparam int FRAME_W    = 44;
  localparam int ORD_W      = 4;
  localparam int CPU_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 44;

  localparam logic [ORD_W-1:0] NO_ORDER = 4'd15;

  localparam logic [12:0] USABLE_PAGES_RST = 13'd4096;
  localparam logic [43:0] POOL_BASE_RST    = 44'd0;
  localparam logic [11:0] HIGH_MARK_RST    = 12'd64;
  localparam logic [6:0]  BATCH_RST        = 7'd32;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    RS_OK      = 2'd0,
    RS_NOMEM   = 2'd1,
    RS_BADFREE = 2'd2
  } res_status_t;

  typedef enum logic [1:0] {
    PG_USED  = 2'd0,
    PG_POOL  = 2'd1,
    PG_CACHE = 2'd2
  } pg_state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_USABLE_PAGES = 2'd0,
    REG_POOL_BASE    = 2'd1,
    REG_HIGH_MARK    = 2'd2,
    REG_BATCH        = 2'd3
  } reg_idx_t;

  typedef struct packed {
    op_t                op;
    logic [ORD_W-1:0]   order;
    logic [CPU_W-1:0]   cpu;
    logic [FRAME_W-1:0] frame;
  } req_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_out;
    res_status_t        status;
  } rsp_t;

  typedef struct packed {
    logic [12:0] usable_pages;
    logic [43:0] pool_base_frame;
    logic [11:0] cache_high_mark;
    logic [6:0]  batch_size;
  } cfg_t;

  // per-page state kept in the page memory
  typedef struct packed {
    pg_state_t        st;
    logic [ORD_W-1:0] ord;
  } meta_t;

  typedef struct packed {
    logic        ready;
    logic        done;
    logic        has_page;
    res_status_t status;
  } core_stat_t;

endpackage

// File: sv/bac_ram.sv
// Simple dual-port RAM: one write, one registered read per cycle.
module bac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/bac_core.sv
// Allocator sequencer: free lists, CPU caches and the page state memories.
`include "buddy_allocator_with_cpu_caches_unit_assert.svh"

module bac_core #(
  parameter int NUM_PAGES  = bac_pkg::NUM_PAGES_DEF,
  parameter int NUM_ORDERS = bac_pkg::NUM_ORDERS_DEF,
  parameter int NUM_CPUS   = bac_pkg::NUM_CPUS_DEF,
  localparam int PW = $clog2(NUM_PAGES)
) (
  input  logic                clk,
  input  logic                rst,
  input  bac_pkg::cfg_t       cfg,
  input  logic                start,
  input  bac_pkg::req_t       req,
  input  logic                take,
  output bac_pkg::core_stat_t stat,
  output logic [PW-1:0]       res_page
);

  localparam int CW  = PW + 1;
  localparam int XW  = ((CW > 16) ? CW : 16) + 1;
  localparam int OIW = (NUM_ORDERS > 1) ? $clog2(NUM_ORDERS) : 1;
  localparam int CPW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_DISPATCH,
    ST_A_POP_RD, ST_A_POP_AP, ST_A_BIG_RET,
    ST_A_REF_FIRST, ST_A_REF_LOOP, ST_A_REF_PUSH,
    ST_STEAL_FIND, ST_STEAL_RD, ST_STEAL_AP,
    ST_F_CHK, ST_OV_RD, ST_OV_CK, ST_AN_RD, ST_AN_CK,
    ST_F_ACT, ST_F_HI, ST_FL_LOOP, ST_FL_AP,
    ST_T_FIND, ST_T_SPLIT,
    ST_G_START, ST_G_LOOP, ST_G_CK, ST_G_MRG, ST_G_END,
    ST_UL_RD, ST_UL_AP, ST_DONE
  } state_t;

  function automatic logic [CPW-1:0] cpu_mod(input logic [bac_pkg::CPU_W-1:0] c);
    logic [4:0] v;
    v = {3'b000, c};
    for (int i = 0; i < 3; i++) begin
      if (v >= 5'(NUM_CPUS)) v = v - 5'(NUM_CPUS);
    end
    return v[CPW-1:0];
  endfunction

  state_t st, ret, ul_ret;

  bac_pkg::op_t            op;
  logic [bac_pkg::ORD_W-1:0] ord;
  logic [CPW-1:0]          cpu;
  logic [43:0]             frame;
  logic [43:0]             off;
  logic [PW-1:0]           res_p;
  bac_pkg::res_status_t    res_st;

  logic [bac_pkg::ORD_W-1:0] tk_ord, tk_cur;
  logic [PW-1:0]             tk_p;
  logic                      tk_ok;
  logic [bac_pkg::ORD_W-1:0] ul_o;
  logic [PW-1:0]             ul_p;
  logic [PW-1:0]             g_idx, g_b;
  logic [bac_pkg::ORD_W-1:0] g_ord;
  logic [PW-1:0]             pg;
  logic [XW-1:0]             ov_j;
  logic [4:0]                ao;
  logic [6:0]                k, kn;
  logic [CPW-1:0]            sc;
  logic [PW-1:0]             clr;

  logic [PW-1:0]         ol_head [NUM_ORDERS];
  logic [PW-1:0]         ol_tail [NUM_ORDERS];
  logic [NUM_ORDERS-1:0] ol_ne;
  logic [PW-1:0]         ch_head [NUM_CPUS];
  logic [PW-1:0]         ch_tail [NUM_CPUS];
  logic [CW-1:0]         ch_cnt  [NUM_CPUS];

  // memory ports
  logic            meta_we;
  logic [PW-1:0]   meta_wa, meta_ra;
  bac_pkg::meta_t  meta_wd, meta_rd;
  logic            nx_we, pv_we;
  logic [PW-1:0]   nx_wa, nx_wd, pv_wa, pv_wd, lk_ra, nx_rd, pv_rd;

  logic                      op_en, cp_en;
  logic [bac_pkg::ORD_W-1:0] op_o;
  logic [PW-1:0]             op_p, cp_p;

  logic [CW-1:0]             pool;
  logic                      ord_big;
  logic [XW-1:0]             sz;
  logic                      bad_free;
  logic                      tf_found;
  logic [bac_pkg::ORD_W-1:0] tf_cur;
  logic                      sf_found;
  logic [CPW-1:0]            sf_i;
  logic [XW-1:0]             split_b, g_bw;
  logic                      g_last;
  logic [PW-1:0]             an_h;
  logic                      ul_head, ul_tail;
  logic                      merge_ok;

  bac_ram #(.WIDTH($bits(bac_pkg::meta_t)), .DEPTH(NUM_PAGES)) u_meta (
    .clk(clk), .we(meta_we), .waddr(meta_wa), .wdata(meta_wd),
    .raddr(meta_ra), .rdata(meta_rd)
  );

  bac_ram #(.WIDTH(PW), .DEPTH(NUM_PAGES)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(lk_ra), .rdata(nx_rd)
  );

  bac_ram #(.WIDTH(PW), .DEPTH(NUM_PAGES)) u_prev (
    .clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(lk_ra), .rdata(pv_rd)
  );

  // shared datapath terms
  always_comb begin
    pool = (32'(cfg.usable_pages) < 32'(NUM_PAGES)) ? CW'(cfg.usable_pages)
                                                    : CW'(NUM_PAGES);
    ord_big = ({1'b0, ord} >= 5'(NUM_ORDERS));
    sz = XW'(1) << ord;
    bad_free = (off >= 44'(pool)) || ((off[XW-1:0] & (sz - XW'(1))) != '0) ||
               (XW'(off[CW-1:0]) + sz > XW'(pool));

    tf_found = 1'b0;
    tf_cur   = '0;
    for (int i = NUM_ORDERS - 1; i >= 0; i--) begin
      if (ol_ne[i] && (5'(i) >= {1'b0, tk_ord})) begin
        tf_found = 1'b1;
        tf_cur   = bac_pkg::ORD_W'(i);
      end
    end

    sf_found = 1'b0;
    sf_i     = '0;
    for (int i = NUM_CPUS - 1; i >= 0; i--) begin
      if ((CPW'(i) != cpu) && (ch_cnt[i] != '0)) begin
        sf_found = 1'b1;
        sf_i     = CPW'(i);
      end
    end

    split_b = XW'(tk_p) + (XW'(1) << (tk_cur - 4'd1));
    g_bw    = XW'(g_idx) ^ (XW'(1) << g_ord);
    g_last  = ({1'b0, g_ord} + 5'd1 >= 5'(NUM_ORDERS));
    for (int i = 0; i < PW; i++) begin
      an_h[i] = pg[i] & (5'(i) >= ao);
    end

    ul_head  = (ol_head[ul_o[OIW-1:0]] == ul_p);
    ul_tail  = (ol_tail[ul_o[OIW-1:0]] == ul_p);
    merge_ok = (meta_rd.st == bac_pkg::PG_POOL) && (meta_rd.ord == g_ord);
  end

  // memory control per state
  always_comb begin
    meta_we = 1'b0;
    meta_wa = clr;
    meta_wd = '{st: bac_pkg::PG_USED, ord: bac_pkg::NO_ORDER};
    meta_ra = g_bw[PW-1:0];
    lk_ra   = ul_p;
    nx_we   = 1'b0;
    nx_wa   = '0;
    nx_wd   = '0;
    pv_we   = 1'b0;
    pv_wa   = '0;
    pv_wd   = '0;
    op_en   = 1'b0;
    op_o    = g_ord;
    op_p    = g_idx;
    cp_en   = 1'b0;
    cp_p    = pg;

    case (st)
      ST_CLEAR: begin
        meta_we = 1'b1;
      end
      ST_UL_AP: begin
        if (!ul_head && !ul_tail) begin
          nx_we = 1'b1;
          nx_wa = pv_rd;
          nx_wd = nx_rd;
          pv_we = 1'b1;
          pv_wa = nx_rd;
          pv_wd = pv_rd;
        end
      end
      ST_T_SPLIT: begin
        if (tk_cur > tk_ord) begin
          if (split_b < XW'(NUM_PAGES)) begin
            meta_we = 1'b1;
            meta_wa = split_b[PW-1:0];
            meta_wd = '{st: bac_pkg::PG_POOL, ord: tk_cur - 4'd1};
            op_en   = 1'b1;
            op_o    = tk_cur - 4'd1;
            op_p    = split_b[PW-1:0];
          end
        end else begin
          meta_we = 1'b1;
          meta_wa = tk_p;
          meta_wd = '{st: bac_pkg::PG_USED, ord: tk_ord};
        end
      end
      ST_A_POP_RD, ST_FL_LOOP: begin
        lk_ra = ch_head[cpu];
      end
      ST_A_POP_AP: begin
        meta_we = 1'b1;
        meta_wa = ch_head[cpu];
        meta_wd = '{st: bac_pkg::PG_USED, ord: 4'd0};
      end
      ST_A_REF_PUSH: begin
        if (tk_ok) begin
          meta_we = 1'b1;
          meta_wa = tk_p;
          meta_wd = '{st: bac_pkg::PG_CACHE, ord: 4'd0};
          cp_en   = 1'b1;
          cp_p    = tk_p;
        end
      end
      ST_STEAL_RD: begin
        lk_ra = ch_head[sc];
      end
      ST_STEAL_AP: begin
        cp_en = 1'b1;
        cp_p  = ch_head[sc];
      end
      ST_OV_RD: begin
        meta_ra = pg + ov_j[PW-1:0];
      end
      ST_AN_RD: begin
        meta_ra = an_h;
      end
      ST_F_ACT: begin
        if (ord == '0) begin
          meta_we = 1'b1;
          meta_wa = pg;
          meta_wd = '{st: bac_pkg::PG_CACHE, ord: 4'd0};
          cp_en   = 1'b1;
        end
      end
      ST_G_START: begin
        meta_we = 1'b1;
        meta_wa = g_idx;
      end
      ST_G_CK: begin
        if (merge_ok) begin
          meta_we = 1'b1;
          meta_wa = g_b;
        end
      end
      ST_G_END: begin
        meta_we = 1'b1;
        meta_wa = g_idx;
        meta_wd = '{st: bac_pkg::PG_POOL, ord: g_ord};
        op_en   = 1'b1;
      end
      default: begin
      end
    endcase

    // append to an order list tail
    if (op_en && ol_ne[op_o[OIW-1:0]]) begin
      nx_we = 1'b1;
      nx_wa = ol_tail[op_o[OIW-1:0]];
      nx_wd = op_p;
      pv_we = 1'b1;
      pv_wa = op_p;
      pv_wd = ol_tail[op_o[OIW-1:0]];
    end
    // append to the requesting CPU's cache
    if (cp_en && (ch_cnt[cpu] != '0)) begin
      nx_we = 1'b1;
      nx_wa = ch_tail[cpu];
      nx_wd = cp_p;
      pv_we = 1'b1;
      pv_wa = cp_p;
      pv_wd = ch_tail[cpu];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= ST_CLEAR;
      clr    <= '0;
      ol_ne  <= '0;
      ch_cnt <= '{default: '0};
    end else begin
      case (st)
        ST_CLEAR: begin
          clr <= clr + PW'(1);
          if (clr == PW'(NUM_PAGES - 1)) st <= ST_IDLE;
        end
        ST_IDLE: begin
          if (start) begin
            op     <= req.op;
            ord    <= req.order;
            cpu    <= cpu_mod(req.cpu);
            frame  <= req.frame;
            res_st <= bac_pkg::RS_OK;
            res_p  <= '0;
            st     <= ST_DISPATCH;
          end
        end
        ST_DISPATCH: begin
          off <= frame - cfg.pool_base_frame;
          if (op == bac_pkg::OP_ALLOC) begin
            if (ord_big) begin
              res_st <= bac_pkg::RS_NOMEM;
              st     <= ST_DONE;
            end else if (ord != '0) begin
              tk_ord <= ord;
              ret    <= ST_A_BIG_RET;
              st     <= ST_T_FIND;
            end else if (ch_cnt[cpu] != '0) begin
              st <= ST_A_POP_RD;
            end else begin
              tk_ord <= '0;
              ret    <= ST_A_REF_FIRST;
              st     <= ST_T_FIND;
            end
          end else if (ord_big) begin
            res_st <= bac_pkg::RS_BADFREE;
            st     <= ST_DONE;
          end else begin
            st <= ST_F_CHK;
          end
        end
        ST_A_POP_RD: st <= ST_A_POP_AP;
        ST_A_POP_AP: begin
          res_p       <= ch_head[cpu];
          ch_head[cpu] <= nx_rd;
          ch_cnt[cpu]  <= ch_cnt[cpu] - CW'(1);
          st          <= ST_DONE;
        end
        ST_A_BIG_RET: begin
          if (tk_ok) res_p <= tk_p;
          else res_st <= bac_pkg::RS_NOMEM;
          st <= ST_DONE;
        end
        ST_A_REF_FIRST: begin
          if (!tk_ok) begin
            st <= ST_STEAL_FIND;
          end else begin
            res_p <= tk_p;
            k     <= '0;
            kn    <= (cfg.batch_size == '0) ? 7'd0 : cfg.batch_size - 7'd1;
            st    <= ST_A_REF_LOOP;
          end
        end
        ST_A_REF_LOOP: begin
          if (k < kn) begin
            tk_ord <= '0;
            ret    <= ST_A_REF_PUSH;
            st     <= ST_T_FIND;
          end else begin
            st <= ST_DONE;
          end
        end
        ST_A_REF_PUSH: begin
          if (!tk_ok) begin
            st <= ST_DONE;
          end else begin
            k  <= k + 7'd1;
            st <= ST_A_REF_LOOP;
          end
        end
        ST_STEAL_FIND: begin
          if (!sf_found) begin
            res_st <= bac_pkg::RS_NOMEM;
            st     <= ST_DONE;
          end else begin
            sc <= sf_i;
            st <= ST_STEAL_RD;
          end
        end
        ST_STEAL_RD: begin
          st <= (ch_cnt[sc] == '0) ? ST_A_POP_RD : ST_STEAL_AP;
        end
        ST_STEAL_AP: begin
          ch_head[sc] <= nx_rd;
          ch_cnt[sc]  <= ch_cnt[sc] - CW'(1);
          st          <= ST_STEAL_RD;
        end
        ST_F_CHK: begin
          if (bad_free) begin
            res_st <= bac_pkg::RS_BADFREE;
            st     <= ST_DONE;
          end else begin
            pg   <= off[PW-1:0];
            ov_j <= '0;
            st   <= ST_OV_RD;
          end
        end
        ST_OV_RD: st <= ST_OV_CK;
        ST_OV_CK: begin
          if (meta_rd.st != bac_pkg::PG_USED) begin
            st <= ST_DONE;  // overlaps free memory: ignored
          end else if (ov_j + XW'(1) == sz) begin
            ao <= {1'b0, ord} + 5'd1;
            st <= ST_AN_RD;
          end else begin
            ov_j <= ov_j + XW'(1);
            st   <= ST_OV_RD;
          end
        end
        ST_AN_RD: begin
          st <= (ao >= 5'(NUM_ORDERS)) ? ST_F_ACT : ST_AN_CK;
        end
        ST_AN_CK: begin
          if (meta_rd.st == bac_pkg::PG_POOL && {1'b0, meta_rd.ord} == ao) begin
            st <= ST_DONE;  // inside a larger free block
          end else begin
            ao <= ao + 5'd1;
            st <= ST_AN_RD;
          end
        end
        ST_F_ACT: begin
          if (ord != '0) begin
            g_idx <= pg;
            g_ord <= ord;
            ret   <= ST_DONE;
            st    <= ST_G_START;
          end else begin
            st <= ST_F_HI;
          end
        end
        ST_F_HI: begin
          if (32'(ch_cnt[cpu]) > 32'(cfg.cache_high_mark)) begin
            kn <= (32'(cfg.batch_size) < 32'(ch_cnt[cpu])) ? cfg.batch_size
                                                           : 7'(ch_cnt[cpu]);
            k  <= '0;
            st <= ST_FL_LOOP;
          end else begin
            st <= ST_DONE;
          end
        end
        ST_FL_LOOP: begin
          st <= (k < kn) ? ST_FL_AP : ST_DONE;
        end
        ST_FL_AP: begin
          g_idx        <= ch_head[cpu];
          g_ord        <= '0;
          ch_head[cpu] <= nx_rd;
          ch_cnt[cpu]  <= ch_cnt[cpu] - CW'(1);
          k            <= k + 7'd1;
          ret          <= ST_FL_LOOP;
          st           <= ST_G_START;
        end
        ST_T_FIND: begin
          if (!tf_found) begin
            tk_ok <= 1'b0;
            st    <= ret;
          end else begin
            tk_cur <= tf_cur;
            tk_p   <= ol_head[tf_cur[OIW-1:0]];
            ul_o   <= tf_cur;
            ul_p   <= ol_head[tf_cur[OIW-1:0]];
            ul_ret <= ST_T_SPLIT;
            st     <= ST_UL_RD;
          end
        end
        ST_T_SPLIT: begin
          if (tk_cur > tk_ord) begin
            tk_cur <= tk_cur - 4'd1;
          end else begin
            tk_ok <= 1'b1;
            st    <= ret;
          end
        end
        ST_G_START: st <= ST_G_LOOP;
        ST_G_LOOP: begin
          if (g_last || (g_bw >= XW'(pool))) begin
            st <= ST_G_END;
          end else begin
            g_b <= g_bw[PW-1:0];
            st  <= ST_G_CK;
          end
        end
        ST_G_CK: begin
          if (merge_ok) begin
            ul_o   <= g_ord;
            ul_p   <= g_b;
            ul_ret <= ST_G_MRG;
            st     <= ST_UL_RD;
          end else begin
            st <= ST_G_END;
          end
        end
        ST_G_MRG: begin
          if (g_b < g_idx) g_idx <= g_b;
          g_ord <= g_ord + 4'd1;
          st    <= ST_G_LOOP;
        end
        ST_G_END: st <= ret;
        ST_UL_RD: st <= ST_UL_AP;
        ST_UL_AP: begin
          if (ul_head && ul_tail) ol_ne[ul_o[OIW-1:0]] <= 1'b0;
          else if (ul_head) ol_head[ul_o[OIW-1:0]] <= nx_rd;
          else if (ul_tail) ol_tail[ul_o[OIW-1:0]] <= pv_rd;
          st <= ul_ret;
        end
        ST_DONE: begin
          if (take) st <= ST_IDLE;
        end
        default: st <= ST_IDLE;
      endcase

      if (op_en) begin
        if (!ol_ne[op_o[OIW-1:0]]) begin
          ol_head[op_o[OIW-1:0]] <= op_p;
          ol_ne[op_o[OIW-1:0]]   <= 1'b1;
        end
        ol_tail[op_o[OIW-1:0]] <= op_p;
      end
      if (cp_en) begin
        if (ch_cnt[cpu] == '0) ch_head[cpu] <= cp_p;
        ch_tail[cpu] <= cp_p;
        ch_cnt[cpu]  <= ch_cnt[cpu] + CW'(1);
      end
    end
  end

  assign stat.ready    = (st == ST_IDLE);
  assign stat.done     = (st == ST_DONE);
  assign stat.has_page = (op == bac_pkg::OP_ALLOC) && (res_st == bac_pkg::RS_OK);
  assign stat.status   = res_st;
  assign res_page      = res_p;

  `BAC_ASSERT_ALWAYS(a_clear_after_reset, rst |=> !stat.ready, "ready right after reset")
  `BAC_ASSERT(a_start_busy, start |=> !stat.ready && !stat.done, "start did not leave idle")
  `BAC_ASSERT(a_done_holds, stat.done && !take |=> stat.done, "result dropped before taken")

endmodule

// File: sv/buddy_allocator_with_cpu_caches_unit.sv
// Top level: configuration registers, request/response handshake, result register.
`include "buddy_allocator_with_cpu_caches_unit_assert.svh"

// Buddy page allocator with FIFO free lists per order and a FIFO page cache
// per CPU. After reset all NUM_PAGES entries (4096 by default) of the page
// state memory are cleared while no request is taken; configuration
// writes are always taken. One request is worked on at a time, stepping
// through the page state and link memories with one access each per cycle.
// A cache hit pops the CPU's cache; a buddy allocation splits one order at
// a time; a refill also moves pages into the cache, splitting as needed; a
// steal moves another CPU's whole cache page by page; a free checks each
// page of the block and each larger order. Each page or block returned to
// the pool is merged with its buddy level by level. The result sits in an
// output register, so the next request is taken while the previous
// response waits.
module buddy_allocator_with_cpu_caches_unit #(
  parameter int NUM_PAGES  = bac_pkg::NUM_PAGES_DEF,
  parameter int NUM_ORDERS = bac_pkg::NUM_ORDERS_DEF,
  parameter int NUM_CPUS   = bac_pkg::NUM_CPUS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  bac_pkg::req_t                     req,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output bac_pkg::rsp_t                     rsp,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bac_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bac_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int PW = $clog2(NUM_PAGES);

  bac_pkg::cfg_t       cfg;
  bac_pkg::core_stat_t stat;
  logic [PW-1:0]       res_page;
  logic                start;
  logic                load;

  assign cfg_ready = 1'b1;
  assign req_stall = !stat.ready;
  assign start     = req_valid && stat.ready;
  assign load      = stat.done && (!rsp_valid || !rsp_stall);

  bac_core #(
    .NUM_PAGES(NUM_PAGES), .NUM_ORDERS(NUM_ORDERS), .NUM_CPUS(NUM_CPUS)
  ) u_core (
    .clk(clk), .rst(rst), .cfg(cfg), .start(start), .req(req),
    .take(load), .stat(stat), .res_page(res_page)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.usable_pages    <= bac_pkg::USABLE_PAGES_RST;
      cfg.pool_base_frame <= bac_pkg::POOL_BASE_RST;
      cfg.cache_high_mark <= bac_pkg::HIGH_MARK_RST;
      cfg.batch_size      <= bac_pkg::BATCH_RST;
      rsp_valid           <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          bac_pkg::REG_USABLE_PAGES: cfg.usable_pages    <= cfg_data[12:0];
          bac_pkg::REG_POOL_BASE:    cfg.pool_base_frame <= cfg_data[43:0];
          bac_pkg::REG_HIGH_MARK:    cfg.cache_high_mark <= cfg_data[11:0];
          bac_pkg::REG_BATCH:        cfg.batch_size      <= cfg_data[6:0];
          default: begin
          end
        endcase
      end
      if (load) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
    end
    if (load) begin
      rsp.frame_out <= stat.has_page ? cfg.pool_base_frame + 44'(res_page) : '0;
      rsp.status    <= stat.status;
    end
  end

  `BAC_ASSERT(a_one_request, req_valid && !req_stall |=> req_stall, "second request taken")

endmodule

// File: bench/bac_alloc_monitor.sv
// Monitor and scoreboard for the buddy allocator: mirrors allocator state and checks every response.
module bac_alloc_monitor
  import bac_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  logic                  req_stall,
  input  req_t                  req,
  input  logic                  rsp_valid,
  input  logic                  rsp_stall,
  input  rsp_t                  rsp,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NP = NUM_PAGES_DEF;
  localparam int NO = NUM_ORDERS_DEF;
  localparam int NC = NUM_CPUS_DEF;

  logic [ORD_W-1:0] pg_ord[NP];
  pg_state_t        pg_st[NP];
  int unsigned      nxt[NP], prv[NP];
  int unsigned      fl_head[NO], fl_tail[NO];
  bit               fl_busy[NO];
  int unsigned      pc_head[NC], pc_tail[NC], pc_cnt[NC];

  logic [12:0] usable;
  logic [43:0] base;
  logic [11:0] high_mark;
  logic [6:0]  batch;

  rsp_t expected_rsp[$];

  function automatic int unsigned pool_pages();
    return (usable < NP) ? int'(usable) : NP;
  endfunction

  function automatic void fl_push(int unsigned o, int unsigned p);
    if (!fl_busy[o]) begin
      fl_head[o] = p;
      fl_busy[o] = 1;
    end else begin
      nxt[fl_tail[o]] = p;
      prv[p] = fl_tail[o];
    end
    fl_tail[o] = p;
  endfunction

  function automatic void fl_unlink(int unsigned o, int unsigned p);
    bit h, t;
    h = fl_head[o] == p;
    t = fl_tail[o] == p;
    if (h && t) fl_busy[o] = 0;
    else if (h) fl_head[o] = nxt[p];
    else if (t) fl_tail[o] = prv[p];
    else begin
      nxt[prv[p]] = nxt[p];
      prv[nxt[p]] = prv[p];
    end
  endfunction

  function automatic void pc_push(int unsigned c, int unsigned p);
    if (pc_cnt[c] == 0) pc_head[c] = p;
    else begin
      nxt[pc_tail[c]] = p;
      prv[p] = pc_tail[c];
    end
    pc_tail[c] = p;
    pc_cnt[c]++;
  endfunction

  function automatic int unsigned pc_pop(int unsigned c);
    int unsigned p;
    p = pc_head[c];
    pc_head[c] = nxt[p];
    pc_cnt[c]--;
    return p;
  endfunction

  function automatic bit pool_take(int unsigned o, output int unsigned p);
    int unsigned cur, b;
    cur = o;
    p = 0;
    while (cur < NO && !fl_busy[cur]) cur++;
    if (cur >= NO) return 0;
    p = fl_head[cur];
    fl_unlink(cur, p);
    pg_st[p] = PG_USED;
    while (cur > o) begin
      cur--;
      b = p + (1 << cur);
      if (b >= NP) continue;
      pg_st[b] = PG_POOL;
      pg_ord[b] = ORD_W'(cur);
      fl_push(cur, b);
    end
    pg_ord[p] = ORD_W'(o);
    return 1;
  endfunction

  function automatic void pool_return(int unsigned idx, int unsigned o);
    int unsigned lim, b;
    lim = pool_pages();
    pg_st[idx] = PG_USED;
    pg_ord[idx] = NO_ORDER;
    while (o + 1 < NO) begin
      b = idx ^ (1 << o);
      if (b >= lim || pg_st[b] != PG_POOL || pg_ord[b] != o) break;
      fl_unlink(o, b);
      pg_st[b] = PG_USED;
      pg_ord[b] = NO_ORDER;
      if (b < idx) idx = b;
      o++;
    end
    pg_st[idx] = PG_POOL;
    pg_ord[idx] = ORD_W'(o);
    fl_push(o, idx);
  endfunction

  // any page already free or cached, or an enclosing free block
  function automatic bit overlaps_free(int unsigned idx, int unsigned o);
    int unsigned h;
    for (int unsigned j = 0; j < (1 << o); j++)
      if (pg_st[idx + j] != PG_USED) return 1;
    for (int unsigned k = o + 1; k < NO; k++) begin
      h = idx & ~((1 << k) - 1);
      if (h < NP && pg_st[h] == PG_POOL && pg_ord[h] == k) return 1;
    end
    return 0;
  endfunction

  function automatic rsp_t predict_rsp(req_t r);
    rsp_t o;
    int unsigned c, ord, p, q, extra, n;
    bit ok;
    longint unsigned off, lim, sz;
    logic [43:0] diff;
    o = '0;
    o.status = RS_OK;
    c = r.cpu % NC;
    ord = r.order;
    ok = 0;
    p = 0;
    if (r.op == OP_ALLOC) begin
      if (ord >= NO) ok = 0;
      else if (ord > 0) ok = pool_take(ord, p);
      else if (pc_cnt[c] > 0) begin
        p = pc_pop(c);
        pg_st[p] = PG_USED;
        ok = 1;
      end else if (pool_take(0, p)) begin
        extra = (batch != 0) ? batch - 1 : 0;
        for (int unsigned k = 0; k < extra; k++) begin
          if (!pool_take(0, q)) break;
          pg_st[q] = PG_CACHE;
          pg_ord[q] = 0;
          pc_push(c, q);
        end
        ok = 1;
      end else begin
        // steal the whole cache of the lowest other CPU that has one
        for (int unsigned i = 0; i < NC && !ok; i++) begin
          if (i == c || pc_cnt[i] == 0) continue;
          while (pc_cnt[i] > 0) pc_push(c, pc_pop(i));
          p = pc_pop(c);
          pg_st[p] = PG_USED;
          ok = 1;
        end
      end
      if (ok) o.frame_out = base + 44'(p);
      else o.status = RS_NOMEM;
      return o;
    end
    if (ord >= NO) begin
      o.status = RS_BADFREE;
      return o;
    end
    diff = r.frame - base;
    off = diff;
    lim = pool_pages();
    sz = 64'd1 << ord;
    if (off >= lim || (off & (sz - 1)) != 0 || off + sz > lim) begin
      o.status = RS_BADFREE;
      return o;
    end
    p = 32'(off);
    if (overlaps_free(p, ord)) return o;
    if (ord > 0) begin
      pool_return(p, ord);
      return o;
    end
    pg_st[p] = PG_CACHE;
    pg_ord[p] = 0;
    pc_push(c, p);
    if (pc_cnt[c] > high_mark) begin
      n = (batch < pc_cnt[c]) ? batch : pc_cnt[c];
      for (int unsigned k = 0; k < n; k++) begin
        q = pc_pop(c);
        pool_return(q, 0);
      end
    end
    return o;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < NP; i++) begin
        pg_ord[i] = NO_ORDER;
        pg_st[i] = PG_USED;
        nxt[i] = 0;
        prv[i] = 0;
      end
      for (int i = 0; i < NO; i++) begin
        fl_busy[i] = 0;
        fl_head[i] = 0;
        fl_tail[i] = 0;
      end
      for (int i = 0; i < NC; i++) begin
        pc_cnt[i] = 0;
        pc_head[i] = 0;
        pc_tail[i] = 0;
      end
      usable = USABLE_PAGES_RST;
      base = POOL_BASE_RST;
      high_mark = HIGH_MARK_RST;
      batch = BATCH_RST;
      expected_rsp.delete();
      pending = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_USABLE_PAGES: usable = cfg_data[12:0];
          REG_POOL_BASE:    base = cfg_data[43:0];
          REG_HIGH_MARK:    high_mark = cfg_data[11:0];
          REG_BATCH:        batch = cfg_data[6:0];
          default: ;
        endcase
      end
      if (req_valid && !req_stall) expected_rsp.push_back(predict_rsp(req));
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp.size() == 0) begin
          $error("response with no request outstanding: frame_out %h status %0d",
                 rsp.frame_out, rsp.status);
          errors++;
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.frame_out !== want.frame_out) begin
            $error("frame_out expected %h actual %h", want.frame_out, rsp.frame_out);
            errors++;
          end
          if (rsp.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, rsp.status);
            errors++;
          end
        end
      end
      pending = expected_rsp.size();
    end
  end

  initial errors = 0;
endmodule

// File: bench/buddy_allocator_with_cpu_caches_unit_tb.sv
// Testbench top for the buddy allocator: clock, reset, stimulus and verdict.
module buddy_allocator_with_cpu_caches_unit_tb;
  import bac_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 10000000;

  logic clk, rst;
  logic req_valid, req_stall, rsp_valid, rsp_stall, cfg_valid, cfg_ready;
  req_t req;
  rsp_t rsp;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int errors, pending;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [ORD_W-1:0]   order;
  } blk_t;

  req_t sent_reqs[$];   // accepted requests awaiting response
  blk_t held_blocks[$]; // blocks currently allocated to us
  bit   quiet, hold_rsp;
  int   cycles;

  buddy_allocator_with_cpu_caches_unit dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  bac_alloc_monitor mon (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
        $display("[buddy_allocator_with_cpu_caches_unit] ERROR");
        $finish;
      end
    end
  end

  // responder: random stalls, plus one long hold-off on request
  initial begin
    int left;
    bit st;
    left = 0;
    st = 0;
    rsp_stall = 0;
    forever begin
      @(posedge clk);
      if (left > 0) left--;
      else if (hold_rsp) begin
        hold_rsp = 0;
        st = 1;
        left = 400;
      end else begin
        st = !quiet && $urandom_range(0, 99) < 30;
        if (st) left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 2);
        else left = $urandom_range(0, 4);
      end
      rsp_stall <= st;
    end
  end

  // track which blocks we own, from responses in request order
  always @(posedge clk) begin
    req_t r;
    blk_t b;
    if (!rst && rsp_valid && !rsp_stall && sent_reqs.size() > 0) begin
      r = sent_reqs.pop_front();
      if (r.op == OP_ALLOC && rsp.status == RS_OK) begin
        b.frame = rsp.frame_out;
        b.order = r.order;
        held_blocks.push_back(b);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send(op_t op, int ord, int c, logic [43:0] f);
    int g;
    g = pick_gap();
    if (g > 0) begin
      req_valid <= 0;
      repeat (g) @(posedge clk);
    end
    req.op <= op;
    req.order <= ord[3:0];
    req.cpu <= c[1:0];
    req.frame <= f;
    req_valid <= 1;
    do @(posedge clk); while (req_stall);
    sent_reqs.push_back(req);
  endtask

  task automatic wait_idle();
    req_valid <= 0;
    do @(posedge clk); while (pending != 0 || sent_reqs.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [43:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  task automatic set_config(int pages, logic [43:0] b, int mark, int bat);
    write_reg(REG_USABLE_PAGES, 44'(pages));
    write_reg(REG_POOL_BASE, b);
    write_reg(REG_HIGH_MARK, 44'(mark));
    write_reg(REG_BATCH, 44'(bat));
    held_blocks.delete();
  endtask

  // hand the whole pool in as the largest aligned blocks that fit
  task automatic populate(int pages, logic [43:0] b);
    int idx, o, lim;
    lim = (pages < NUM_PAGES_DEF) ? pages : NUM_PAGES_DEF;
    idx = 0;
    while (idx < lim) begin
      o = NUM_ORDERS_DEF - 1;
      while (o > 0 && ((idx & ((1 << o) - 1)) != 0 || idx + (1 << o) > lim)) o--;
      send(OP_FREE, o, $urandom_range(0, 3), b + 44'(idx));
      idx += 1 << o;
    end
  endtask

  task automatic random_items(int n, logic [43:0] b, bit with_hold);
    int r, k;
    blk_t blk;
    for (int i = 0; i < n; i++) begin
      quiet = (i < 30);
      if (with_hold && i == n / 2) hold_rsp = 1;
      r = $urandom_range(0, 99);
      if (r < 48) begin
        k = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 3);
        if ($urandom_range(0, 49) == 0) k = $urandom_range(4, 15);
        send(OP_ALLOC, k, $urandom_range(0, 3), 44'({$urandom, $urandom}));
      end else if (r < 90 && held_blocks.size() > 0) begin
        k = $urandom_range(0, held_blocks.size() - 1);
        blk = held_blocks[k];
        held_blocks.delete(k);
        send(OP_FREE, blk.order, $urandom_range(0, 3), blk.frame);
      end else if (r < 95) begin
        // arbitrary frame, half the time within 4096 pages of the pool base
        send(OP_FREE, $urandom_range(0, 15), $urandom_range(0, 3),
             ($urandom_range(0, 1) != 0) ? b + 44'($urandom_range(0, 4095))
                                         : 44'({$urandom, $urandom}));
      end else begin
        send(OP_ALLOC, 0, $urandom_range(0, 3), '0);
      end
    end
    quiet = 0;
  endtask

  initial begin
    rst = 1;
    req_valid = 0;
    req = '0;
    cfg_valid = 0;
    cfg_index = REG_USABLE_PAGES;
    cfg_data = '0;
    quiet = 0;
    hold_rsp = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    set_config(4096, 44'd0, 64, 32);
    populate(4096, 44'd0);
    // directed: order limits, bad frees, double free, refill, frame extremes
    send(OP_ALLOC, 15, 0, '0);
    send(OP_ALLOC, 11, 1, '0);
    send(OP_FREE, 15, 2, 44'd0);
    send(OP_FREE, 11, 3, 44'd0);
    send(OP_FREE, 0, 3, {44{1'b1}});
    send(OP_FREE, 1, 0, 44'd1);
    send(OP_FREE, 0, 0, 44'd4095);
    send(OP_ALLOC, 10, 3, {44{1'b1}});
    send(OP_ALLOC, 0, 0, '0);
    send(OP_ALLOC, 0, 1, '0);
    send(OP_ALLOC, 0, 2, '0);
    send(OP_ALLOC, 0, 3, '0);
    send(OP_FREE, 10, 1, 44'd1024);
    send(OP_FREE, 0, 2, 44'd4096);
    send(OP_ALLOC, 9, 2, '0);
    random_items(200, 44'd0, 1);
    wait_idle();

    // single-page pool at the top of the frame space: wrap and steal
    set_config(1, {44{1'b1}}, 1, 1);
    populate(1, {44{1'b1}});
    random_items(120, {44{1'b1}}, 0);
    wait_idle();

    set_config(100, 44'h5_5555_5555, 4095, 64);
    populate(100, 44'h5_5555_5555);
    random_items(160, 44'h5_5555_5555, 0);
    wait_idle();

    set_config(300, 44'hA_AAAA_AAAA, 3, 0);
    populate(300, 44'hA_AAAA_AAAA);
    random_items(150, 44'hA_AAAA_AAAA, 0);
    wait_idle();

    set_config(5000, 44'h123, 2, 127);
    populate(256, 44'h123);
    random_items(150, 44'h123, 0);
    wait_idle();

    repeat (200) @(posedge clk);
    if (errors == 0) $display("[buddy_allocator_with_cpu_caches_unit] OK");
    else $display("[buddy_allocator_with_cpu_caches_unit] ERROR");
    $finish;
  end
endmodule
